FILE: rtl/u8sc_pkg.sv
// Package: shared types and constants of the UTF-8 decoder with space classification.
`default_nettype none

package u8sc_pkg;

    localparam logic [15:0] SPACE_CP = 16'h0020;

    // One queued command: the one or two code points that one input byte yields.
    typedef struct packed {
        logic        two;
        logic [15:0] cp0;
        logic [15:0] cp1;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/u8sc_ifs.sv
// Interfaces: valid/ready channels for input bytes and decoded results.
`default_nettype none

interface u8sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_string;

    modport source (output valid, output byte_value, output end_of_string, input ready);
    modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

interface u8sc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic        is_space;
    logic        last_result;

    modport source (output valid, output code_point, output is_space, output last_result,
                    input ready);
    modport sink   (input valid, input code_point, input is_space, input last_result,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8_decoder_space_classify.sv
// Top level: UTF-8 decoder (up to three bytes) with whitespace classification.
// Path: a byte's results go through the command queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two
//   code points passes through the single result register of the back end twice.
// Reset: synchronous active-low i_rst_n clears sequence state, queue and output valid.
`default_nettype none

module utf8_decoder_space_classify #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8sc_in_if.sink     i_in,
    u8sc_out_if.source  o_out
);

    // Front and back talk only through the command queue; each stalls on its own.
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    u8sc_pkg::t_cmd cmd_in;
    u8sc_pkg::t_cmd cmd_head;

    // Decode bytes; push one command for each byte that yields code points.
    u8sc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    // Hold commands until the back end drains them.
    u8sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (cmd_head)
    );

    // Emit one result per cycle unless stalled; tag whitespace and a byte's last result.
    u8sc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (cmd_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/u8sc_front.sv
// Front end: accept bytes, track the UTF-8 sequence state, queue the code points.
`default_nettype none

module u8sc_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    u8sc_in_if.sink          i_in,
    input  wire logic        i_full,
    output logic             o_push,
    output u8sc_pkg::t_cmd   o_cmd
);

    logic [1:0]  r_pend, n_pend;
    logic [15:0] r_acc, n_acc;
    logic        r_skip, n_skip;

    logic        accept;
    logic        cont;
    logic        cut;
    logic        lead_en;
    logic        main_en;
    logic [15:0] main_cp;
    logic        eos_emit;
    logic [7:0]  b;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.byte_value;
    assign cont       = (b[7:6] == 2'b10);

    always_comb begin
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_skip   = r_skip;
        cut      = 1'b0;
        lead_en  = 1'b0;
        main_en  = 1'b0;
        main_cp  = u8sc_pkg::SPACE_CP;
        eos_emit = 1'b0;

        if (!(r_skip && cont)) begin
            n_skip = 1'b0;
            if (r_pend != 2'd0) begin
                if (cont) begin
                    n_acc  = {r_acc[9:0], b[5:0]};
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        main_en = 1'b1;
                        main_cp = {r_acc[9:0], b[5:0]};
                    end
                end else begin
                    // Cut sequence: emit a space, then decode this byte as a lead.
                    n_pend  = 2'd0;
                    cut     = 1'b1;
                    lead_en = 1'b1;
                end
            end else begin
                lead_en = 1'b1;
            end
        end

        if (lead_en) begin
            if (!b[7]) begin
                main_en = 1'b1;
                main_cp = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
                n_acc  = {11'd0, b[4:0]};
                n_pend = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_acc  = {11'd0, b[4:0]};
                n_pend = 2'd2;
            end else begin
                main_en = 1'b1;
                main_cp = u8sc_pkg::SPACE_CP;
                n_skip  = 1'b1;
            end
        end

        if (i_in.end_of_string) begin
            eos_emit = (n_pend != 2'd0);
            n_pend   = 2'd0;
            n_acc    = 16'd0;
            n_skip   = 1'b0;
        end
    end

    // At most two of the three emit sources are ever active together.
    always_comb begin
        o_push    = accept && (cut || main_en || eos_emit);
        o_cmd.two = (cut && main_en) || (cut && eos_emit) || (main_en && eos_emit);
        o_cmd.cp0 = cut ? u8sc_pkg::SPACE_CP : (main_en ? main_cp : u8sc_pkg::SPACE_CP);
        o_cmd.cp1 = (cut && main_en) ? main_cp : u8sc_pkg::SPACE_CP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_acc  <= 16'd0;
            r_skip <= 1'b0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_skip <= n_skip;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u8sc_queue.sv
// Command queue between the decoding front end and the result back end.
`default_nettype none

module u8sc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u8sc_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output u8sc_pkg::t_cmd      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8sc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/u8sc_back.sv
// Back end: expand queued commands into results, classify whitespace, register output.
`default_nettype none

module u8sc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire u8sc_pkg::t_cmd i_head,
    input  wire logic           i_empty,
    output logic                o_pop,
    u8sc_out_if.source          o_out
);

    logic        r_valid;
    logic        r_sel;
    logic [15:0] r_cp;
    logic        r_space;
    logic        r_last;

    logic        load;
    logic        last;
    logic [15:0] cp;

    function automatic logic space_class(input logic [15:0] c);
        logic hit;
        hit = (c <= 16'h0020) ||
              (c >= 16'h007F && c <= 16'h00A0) ||
              (c >= 16'h2000 && c <= 16'h200B) ||
              (c == 16'h1680) || (c == 16'h180E) || (c == 16'h2028) ||
              (c == 16'h2029) || (c == 16'h205F) || (c == 16'h3000);
        return hit;
    endfunction

    assign load  = !i_empty && (!r_valid || o_out.ready);
    assign last  = r_sel || !i_head.two;
    assign cp    = r_sel ? i_head.cp1 : i_head.cp0;
    assign o_pop = load && last;

    assign o_out.valid       = r_valid;
    assign o_out.code_point  = r_cp;
    assign o_out.is_space    = r_space;
    assign o_out.last_result = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp    <= cp;
            r_space <= space_class(cp);
            r_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !last;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
